FILE: hw/rtl/masked_pose_override_blend_core_defines.svh
// Assertion macros shared by the masked pose override blend RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef MASKED_POSE_OVERRIDE_BLEND_CORE_DEFINES_SVH
`define MASKED_POSE_OVERRIDE_BLEND_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPOB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpob: implication check failed");

// Consequent must hold in the cycle after the antecedent.
`define MPOB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpob: next-cycle check failed");

`endif

FILE: hw/rtl/mpob_pkg.sv
// Package for the masked pose override blend core: formats, codes and types.
// Used by every RTL module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mpob_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int WEIGHT_W    = WEIGHT_BITS + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_BITS;
  localparam int SQ_STAGES   = DATA_W;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int NUM_W       = DATA_W + FRAC_BITS;
  localparam int FIFO_DEPTH  = 2;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_ROTATE    = 2'd1,
    OP_SCALE     = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_LERP  = 2'd1,
    MODE_NLERP = 2'd2
  } mode_t;

  typedef logic [3:0][DATA_W-1:0] vec_t;

  typedef struct packed {
    mode_t               mode;
    logic                rot;
    logic                last;
    logic [WEIGHT_W-1:0] w;
    vec_t                from;
    vec_t                to;
  } item_t;

  typedef struct packed {
    mode_t      mode;
    logic       rot;
    logic       last;
    logic       zero;
    logic [3:0] neg;
    vec_t       val;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mpob_front.sv
// Front end: holds blend_alpha, forms the blend weight and classifies each request.
// Depends on mpob_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpob_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mpob_pkg::WEIGHT_W-1:0]      cfg_wdata,
  output logic [mpob_pkg::WEIGHT_W-1:0]      alpha,
  input  logic                               start,
  input  mpob_pkg::q_stat_t                  stat,
  input  logic [1:0]                         opcode,
  input  logic                               use_mask,
  input  logic [mpob_pkg::WEIGHT_W-1:0]      mask_weight,
  input  mpob_pkg::vec_t                     from_v,
  input  mpob_pkg::vec_t                     to_v,
  input  logic                               last_channel,
  output logic                               busy,
  output logic                               push,
  output mpob_pkg::item_t                    item
);

  localparam int PW = 2 * mpob_pkg::WEIGHT_W;

  logic [mpob_pkg::WEIGHT_W-1:0] a_sat;
  logic [mpob_pkg::WEIGHT_W-1:0] m_sat;
  logic [PW-1:0]                 wprod;
  logic [PW-1:0]                 wround;
  logic [mpob_pkg::WEIGHT_W-1:0] w;
  logic                          rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= '0;
    end else if (cfg_we) begin
      alpha <= cfg_wdata;
    end
  end

  always_comb begin
    a_sat  = (alpha > mpob_pkg::WEIGHT_ONE) ? mpob_pkg::WEIGHT_ONE : alpha;
    m_sat  = (mask_weight > mpob_pkg::WEIGHT_ONE) ? mpob_pkg::WEIGHT_ONE : mask_weight;
    wprod  = PW'(a_sat) * PW'(m_sat);
    wround = (wprod + (PW'(1) << (mpob_pkg::WEIGHT_BITS - 1))) >> mpob_pkg::WEIGHT_BITS;
    w      = use_mask ? wround[mpob_pkg::WEIGHT_W-1:0] : a_sat;
    rot    = (opcode == mpob_pkg::OP_ROTATE);

    item.rot  = rot;
    item.last = last_channel;
    item.w    = w;
    item.to   = to_v;
    if (w == '0) begin
      item.mode = mpob_pkg::MODE_COPY;
      item.from = from_v;
    end else if (w == mpob_pkg::WEIGHT_ONE) begin
      item.mode = mpob_pkg::MODE_COPY;
      item.from = to_v;
    end else begin
      item.mode = rot ? mpob_pkg::MODE_NLERP : mpob_pkg::MODE_LERP;
      item.from = from_v;
    end

    busy = stat.full;
    push = start && !stat.full;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mpob_fifo.sv
// Short request queue between the front end and the blend pipeline.
// Depends on mpob_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_pose_override_blend_core_defines.svh"

module mpob_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mpob_pkg::item_t   din,
  output mpob_pkg::q_stat_t stat,
  output logic              out_valid,
  output mpob_pkg::item_t   dout
);

  localparam int DEPTH = mpob_pkg::FIFO_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mpob_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] count;
  logic             pop;

  always_comb begin
    stat.full  = (count == CNT_W'(DEPTH));
    stat.empty = (count == '0);
    pop        = !stat.empty;
    out_valid  = !stat.empty;
    dout       = mem[rp];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `MPOB_ASSERT_IMPL(a_no_push_full, stat.full, !push)
  `MPOB_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `MPOB_ASSERT_NEXT(a_push_fills, push && stat.empty, !stat.empty)

endmodule

`default_nettype wire

FILE: hw/rtl/mpob_back.sv
// Blend pipeline: lerp, shortest-path flip, squared length, square root and divide.
// Depends on mpob_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_pose_override_blend_core_defines.svh"

module mpob_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  mpob_pkg::item_t                    item,
  output logic                               done,
  output logic signed [mpob_pkg::DATA_W-1:0] out_x,
  output logic signed [mpob_pkg::DATA_W-1:0] out_y,
  output logic signed [mpob_pkg::DATA_W-1:0] out_z,
  output logic signed [mpob_pkg::DATA_W-1:0] out_w,
  output logic                               last_out
);

  localparam int DW       = mpob_pkg::DATA_W;
  localparam int WW       = mpob_pkg::WEIGHT_W;
  localparam int WB       = mpob_pkg::WEIGHT_BITS;
  localparam int PROD_W   = DW + WW + 1;
  localparam int SUM_W    = PROD_W + 1;
  localparam int LERP_W   = SUM_W - WB;
  localparam int DOT_W    = 2 * DW + 2;
  localparam int SQ_N     = mpob_pkg::SQ_STAGES;
  localparam int QW       = mpob_pkg::QUO_W;
  localparam int NW       = mpob_pkg::NUM_W;
  localparam int REM_W    = DW + 2;
  localparam int BACK_LAT = 6 + SQ_N + QW + 1;
  localparam logic signed [LERP_W-1:0] SAT_HI = LERP_W'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [LERP_W-1:0] SAT_LO = -SAT_HI;
  localparam logic signed [SUM_W-1:0]  HALF   = SUM_W'(1) <<< (WB - 1);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DW-1:0]     root;
    logic [2*DW-1:0]   n;
  } sq_t;

  typedef struct packed {
    logic [3:0][DW-1:0] rem;
    logic [3:0][QW-1:0] low;
    logic [3:0][QW-1:0] quo;
    logic [DW-1:0]      len;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t s);
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] test;
    sq_t              r;
    trial = {s.rem, s.n[2*DW-1:2*DW-2]};
    test  = {{(REM_W-DW){1'b0}}, s.root, 2'b01};
    r.n   = {s.n[2*DW-3:0], 2'b00};
    if (trial >= test) begin
      r.rem  = REM_W'(trial - test);
      r.root = {s.root[DW-2:0], 1'b1};
    end else begin
      r.rem  = trial[REM_W-1:0];
      r.root = {s.root[DW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t div_step(input dv_t d);
    logic [DW:0] t;
    dv_t         r;
    r = d;
    for (int c = 0; c < 4; c++) begin
      t        = {d.rem[c], d.low[c][QW-1]};
      r.low[c] = {d.low[c][QW-2:0], 1'b0};
      if (t >= {1'b0, d.len}) begin
        r.rem[c] = DW'(t - {1'b0, d.len});
        r.quo[c] = {d.quo[c][QW-2:0], 1'b1};
      end else begin
        r.rem[c] = t[DW-1:0];
        r.quo[c] = {d.quo[c][QW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [BACK_LAT-1:0] vld;

  mpob_pkg::item_t                 s1_it;
  logic signed [PROD_W-1:0]        s1_pa [4];
  logic signed [PROD_W-1:0]        s1_pb [4];
  logic signed [2*DW-1:0]          s1_dp [4];
  logic signed [PROD_W-1:0]        pa_c  [4];
  logic signed [PROD_W-1:0]        pb_c  [4];
  logic signed [2*DW-1:0]          dp_c  [4];

  mpob_pkg::item_t                 s2_it;
  logic                            s2_flip;
  logic signed [LERP_W-1:0]        s2_rp [4];
  logic signed [LERP_W-1:0]        s2_rm [4];
  logic signed [DOT_W-1:0]         dsum;
  logic signed [SUM_W-1:0]         sp    [4];
  logic signed [SUM_W-1:0]         sm    [4];
  logic signed [SUM_W-1:0]         spf   [4];
  logic signed [SUM_W-1:0]         smf   [4];

  mpob_pkg::res_t                  s3_res;
  mpob_pkg::res_t                  s3_next;
  logic signed [LERP_W-1:0]        lv    [4];

  mpob_pkg::res_t                  s4_res;
  logic [3:0][2*DW-1:0]            s4_sq;

  mpob_pkg::res_t                  s5_res;
  mpob_pkg::res_t                  s5_next;
  logic [2*DW-1:0]                 s5_len2;

  sq_t                             sq_init;
  mpob_pkg::res_t                  sq_head;
  sq_t                             sq_st  [SQ_N];
  mpob_pkg::res_t                  sq_res [SQ_N];

  dv_t                             dv_init;
  dv_t                             dv_st  [QW];
  mpob_pkg::res_t                  dv_res [QW];
  logic [NW-1:0]                   num    [4];

  mpob_pkg::res_t                  o_res;
  logic [3:0][DW-1:0]              o_val;
  logic [3:0][DW-1:0]              o_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[BACK_LAT-2:0], in_valid};
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pa_c[c] = $signed(item.from[c]) * $signed({1'b0, mpob_pkg::WEIGHT_ONE - item.w});
      pb_c[c] = $signed(item.to[c]) * $signed({1'b0, item.w});
      dp_c[c] = $signed(item.from[c]) * $signed(item.to[c]);
    end
  end

  always_ff @(posedge clk) begin
    s1_it <= item;
    for (int c = 0; c < 4; c++) begin
      s1_pa[c] <= pa_c[c];
      s1_pb[c] <= pb_c[c];
      s1_dp[c] <= dp_c[c];
    end
  end

  always_comb begin
    dsum = DOT_W'(s1_dp[0]) + DOT_W'(s1_dp[1]) + DOT_W'(s1_dp[2]) + DOT_W'(s1_dp[3]);
    for (int c = 0; c < 4; c++) begin
      sp[c]  = SUM_W'(s1_pa[c]) + SUM_W'(s1_pb[c]) + HALF;
      sm[c]  = SUM_W'(s1_pa[c]) - SUM_W'(s1_pb[c]) + HALF;
      spf[c] = sp[c] >>> WB;
      smf[c] = sm[c] >>> WB;
    end
  end

  always_ff @(posedge clk) begin
    s2_it   <= s1_it;
    s2_flip <= (s1_it.mode == mpob_pkg::MODE_NLERP) && dsum[DOT_W-1];
    for (int c = 0; c < 4; c++) begin
      s2_rp[c] <= spf[c][LERP_W-1:0];
      s2_rm[c] <= smf[c][LERP_W-1:0];
    end
  end

  always_comb begin
    s3_next.mode = s2_it.mode;
    s3_next.rot  = s2_it.rot;
    s3_next.last = s2_it.last;
    s3_next.zero = 1'b0;
    s3_next.neg  = '0;
    for (int c = 0; c < 4; c++) begin
      lv[c] = s2_flip ? s2_rm[c] : s2_rp[c];
      if (s2_it.rot && lv[c] > SAT_HI) begin
        lv[c] = SAT_HI;
      end else if (s2_it.rot && lv[c] < SAT_LO) begin
        lv[c] = SAT_LO;
      end
      s3_next.val[c] = (s2_it.mode == mpob_pkg::MODE_COPY) ? s2_it.from[c] : lv[c][DW-1:0];
    end
    if (!s2_it.rot) begin
      s3_next.val[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    s3_res <= s3_next;
  end

  always_ff @(posedge clk) begin
    s4_res <= s3_res;
    for (int c = 0; c < 4; c++) begin
      s4_sq[c] <= $signed(s3_res.val[c]) * $signed(s3_res.val[c]);
    end
  end

  always_comb begin
    s5_next = s4_res;
    for (int c = 0; c < 4; c++) begin
      s5_next.neg[c] = s4_res.val[c][DW-1];
      if (s4_res.mode == mpob_pkg::MODE_NLERP && s4_res.val[c][DW-1]) begin
        s5_next.val[c] = -s4_res.val[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    s5_res  <= s5_next;
    s5_len2 <= s4_sq[0] + s4_sq[1] + s4_sq[2] + s4_sq[3];
  end

  always_comb begin
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.n    = s5_len2;
    sq_head      = s5_res;
    sq_head.zero = (s5_len2 == '0) && (s5_res.mode == mpob_pkg::MODE_NLERP);
  end

  always_ff @(posedge clk) begin
    sq_st[0]  <= sqrt_step(sq_init);
    sq_res[0] <= sq_head;
    for (int k = 1; k < SQ_N; k++) begin
      sq_st[k]  <= sqrt_step(sq_st[k-1]);
      sq_res[k] <= sq_res[k-1];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      num[c] = (NW'(sq_res[SQ_N-1].val[c]) << mpob_pkg::FRAC_BITS)
             + NW'(sq_st[SQ_N-1].root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      dv_init.rem[c] <= DW'(num[c][NW-1:QW]);
      dv_init.low[c] <= num[c][QW-1:0];
      dv_init.quo[c] <= '0;
    end
    dv_init.len <= sq_st[SQ_N-1].root;
  end

  mpob_pkg::res_t pr_res;

  always_ff @(posedge clk) begin
    pr_res    <= sq_res[SQ_N-1];
    dv_st[0]  <= div_step(dv_init);
    dv_res[0] <= pr_res;
    for (int j = 1; j < QW; j++) begin
      dv_st[j]  <= div_step(dv_st[j-1]);
      dv_res[j] <= dv_res[j-1];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (dv_res[QW-1].mode != mpob_pkg::MODE_NLERP) begin
        o_next[c] = dv_res[QW-1].val[c];
      end else if (dv_res[QW-1].zero) begin
        o_next[c] = '0;
      end else if (dv_res[QW-1].neg[c]) begin
        o_next[c] = -DW'(dv_st[QW-1].quo[c]);
      end else begin
        o_next[c] = DW'(dv_st[QW-1].quo[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    o_res <= dv_res[QW-1];
    o_val <= o_next;
  end

  always_comb begin
    done     = vld[BACK_LAT-1];
    out_x    = o_val[0];
    out_y    = o_val[1];
    out_z    = o_val[2];
    out_w    = o_val[3];
    last_out = o_res.last;
  end

  `MPOB_ASSERT_IMPL(a_fixed_latency, in_valid, ##BACK_LAT done)
  `MPOB_ASSERT_IMPL(a_w_zero_nonrot, done && !o_res.rot, out_w == '0)
  `MPOB_ASSERT_IMPL(a_zero_len_out, done && o_res.zero, o_val == '0)

endmodule

`default_nettype wire

FILE: hw/rtl/masked_pose_override_blend_core.sv
// Top level of the masked pose override blend core: APB register port and wiring.
// Depends on mpob_pkg, mpob_front, mpob_fifo and mpob_back.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Configure blend_alpha (Q1.16, 17 bits) through the APB port at byte address 0
// while the block is idle. Reads return the current value; pready is always high.
// A request is one joint channel (translation, rotation or scale) and is taken at
// a rising edge where start is high and busy is low. One request can enter every
// cycle while busy is low. Each request yields one result, presented on out_x..out_w
// and last_out for a single cycle with done high, in request order. The latency is
// set by the rotation path: registered stages for lerp, flip and squared length,
// one bit of square root per stage over 32 stages, one operand setup stage, one
// quotient bit per stage over 17 stages and an output register. All channel kinds
// take the same path, so latency is constant.
// The receiver cannot stall; results are always delivered. A two-entry queue
// separates request intake from the pipeline, and busy reflects a full queue.
// Synchronous reset clears blend_alpha, the queue and all in-flight results.

module masked_pose_override_blend_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [1:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         opcode,
  input  logic                               use_mask,
  input  logic [mpob_pkg::WEIGHT_W-1:0]      mask_weight,
  input  logic signed [mpob_pkg::DATA_W-1:0] from_x,
  input  logic signed [mpob_pkg::DATA_W-1:0] from_y,
  input  logic signed [mpob_pkg::DATA_W-1:0] from_z,
  input  logic signed [mpob_pkg::DATA_W-1:0] from_w,
  input  logic signed [mpob_pkg::DATA_W-1:0] to_x,
  input  logic signed [mpob_pkg::DATA_W-1:0] to_y,
  input  logic signed [mpob_pkg::DATA_W-1:0] to_z,
  input  logic signed [mpob_pkg::DATA_W-1:0] to_w,
  input  logic                               last_channel,
  output logic                               done,
  output logic signed [mpob_pkg::DATA_W-1:0] out_x,
  output logic signed [mpob_pkg::DATA_W-1:0] out_y,
  output logic signed [mpob_pkg::DATA_W-1:0] out_z,
  output logic signed [mpob_pkg::DATA_W-1:0] out_w,
  output logic                               last_out
);

  logic                          cfg_we;
  logic [mpob_pkg::WEIGHT_W-1:0] alpha;
  mpob_pkg::vec_t                from_v;
  mpob_pkg::vec_t                to_v;
  mpob_pkg::q_stat_t             stat;
  logic                          push;
  mpob_pkg::item_t               in_item;
  logic                          q_valid;
  mpob_pkg::item_t               q_item;

  always_comb begin
    pready = 1'b1;
    cfg_we = psel && penable && pwrite && (paddr == '0);
    prdata = 32'(alpha);
    from_v = {from_w, from_z, from_y, from_x};
    to_v   = {to_w, to_z, to_y, to_x};
  end

  mpob_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[mpob_pkg::WEIGHT_W-1:0]),
    .alpha        (alpha),
    .start        (start),
    .stat         (stat),
    .opcode       (opcode),
    .use_mask     (use_mask),
    .mask_weight  (mask_weight),
    .from_v       (from_v),
    .to_v         (to_v),
    .last_channel (last_channel),
    .busy         (busy),
    .push         (push),
    .item         (in_item)
  );

  mpob_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (in_item),
    .stat      (stat),
    .out_valid (q_valid),
    .dout      (q_item)
  );

  mpob_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .item     (q_item),
    .done     (done),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .out_w    (out_w),
    .last_out (last_out)
  );

endmodule

`default_nettype wire
